FILE: rtl/ppsc_pkg.sv
// ----------------------------------------------------------------------------
// ppsc_pkg
// shared constants, codes and color helpers for the palette pixel scaler
// ----------------------------------------------------------------------------
package ppsc_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 16;
    localparam int INDEX_W = 8;
    localparam int PHASE_W = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // input item kinds
    localparam logic MODE_PAL_WRITE = 1'b0;
    localparam logic MODE_PIXEL     = 1'b1;

    // color_format codes
    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_RGB555 = 1'b1;

    // scale_mode codes
    localparam logic [1:0] SCALE_DIRECT = 2'd0;
    localparam logic [1:0] SCALE_DROP   = 2'd1;
    localparam logic [1:0] SCALE_SMOOTH = 2'd2;

    // group phases
    localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_THIRD  = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_FOURTH = 2'd3;

    // register select, taken from paddr bit 2
    localparam logic REG_COLOR_FORMAT = 1'b0;
    localparam logic REG_SCALE_MODE   = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic [PHASE_W-1:0]   phase;
        logic                 in_range;
        logic                 line_end;
    } ppsc_stage_t;

    // one channel of the 3:1, 1:1 or 1:3 blend
    function automatic logic [CHAN_W-1:0] blend_chan(
        input logic [CHAN_W-1:0]  prev,
        input logic [CHAN_W-1:0]  cur,
        input logic [PHASE_W-1:0] phase
    );
        logic [CHAN_W+1:0] p1;
        logic [CHAN_W+1:0] c1;
        logic [CHAN_W+1:0] sum;
        logic [CHAN_W-1:0] res;
        p1 = {2'b00, prev};
        c1 = {2'b00, cur};
        case (phase)
            PHASE_SECOND: begin
                sum = (p1 << 1) + p1 + c1;
                res = sum[CHAN_W+1:2];
            end
            PHASE_THIRD: begin
                sum = p1 + c1;
                res = sum[CHAN_W:1];
            end
            PHASE_FOURTH: begin
                sum = p1 + (c1 << 1) + c1;
                res = sum[CHAN_W+1:2];
            end
            default: begin
                sum = c1;
                res = cur;
            end
        endcase
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] pack_color(
        input logic               fmt,
        input logic [COLOR_W-1:0] color
    );
        logic [PIX_W-1:0] res;
        case (fmt)
            FMT_RGB555: res = {1'b0, color[23:19], color[15:11], color[7:3]};
            default:    res = {color[23:19], color[15:10], color[7:3]};
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/ppsc_ram.sv
// ----------------------------------------------------------------------------
// ppsc_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ppsc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ppsc_color.sv
// ----------------------------------------------------------------------------
// ppsc_color
// scale decision, channel blend and rgb565 / rgb555 packing
// ----------------------------------------------------------------------------
module ppsc_color (
    input  logic [ppsc_pkg::COLOR_W-1:0] prev_color,
    input  logic [ppsc_pkg::COLOR_W-1:0] cur_color,
    input  logic [ppsc_pkg::PHASE_W-1:0] phase,
    input  logic [1:0]                   scale_mode,
    input  logic                         color_format,
    output logic                         emit,
    output logic [ppsc_pkg::PIX_W-1:0]   packed_color
);

    logic                         smooth;
    logic                         skip_first;
    logic [ppsc_pkg::COLOR_W-1:0] blended;
    logic [ppsc_pkg::COLOR_W-1:0] chosen;

    always_comb begin
        smooth     = (scale_mode == ppsc_pkg::SCALE_SMOOTH);
        skip_first = smooth || (scale_mode == ppsc_pkg::SCALE_DROP);
        emit       = !(skip_first && (phase == ppsc_pkg::PHASE_FIRST));
        blended    = {ppsc_pkg::blend_chan(prev_color[23:16], cur_color[23:16], phase),
                      ppsc_pkg::blend_chan(prev_color[15:8],  cur_color[15:8],  phase),
                      ppsc_pkg::blend_chan(prev_color[7:0],   cur_color[7:0],   phase)};
        chosen       = smooth ? blended : cur_color;
        packed_color = ppsc_pkg::pack_color(color_format, chosen);
    end

endmodule

FILE: rtl/palette_pixel_scaler.sv
// ----------------------------------------------------------------------------
// palette_pixel_scaler
// indexed pixels through a palette ram to rgb565 / rgb555, with optional 4:3 scaling
//
//   channel  prefix  payload                                        direction
//   input    s_      mode, pixel_index, red, green, blue,
//                    line_start, line_end                           in
//   result   m_      packed_color, line_last                        out
//   config   p       apb write / read of color_format, scale_mode   in
//
// one input transfer per cycle unless the pixel stage is held; a pixel's result
// comes from the palette ram read, then blend and pack into the output register
// palette writes go straight into the ram and give no result
// aresetn clears the phase, previous color, configuration registers and valid flags;
// palette contents are undefined until written
// a stalled result register holds the pixel stage, which holds the input
// ----------------------------------------------------------------------------
module palette_pixel_scaler #(
    parameter int PALETTE_ENTRIES = ppsc_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [ppsc_pkg::INDEX_W-1:0] s_pixel_index,
    input  logic [ppsc_pkg::CHAN_W-1:0]  s_red,
    input  logic [ppsc_pkg::CHAN_W-1:0]  s_green,
    input  logic [ppsc_pkg::CHAN_W-1:0]  s_blue,
    input  logic                         s_line_start,
    input  logic                         s_line_end,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ppsc_pkg::PIX_W-1:0]   m_packed_color,
    output logic                         m_line_last,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppsc_pkg::PADDR_W-1:0] paddr,
    input  logic [ppsc_pkg::PDATA_W-1:0] pwdata,
    output logic [ppsc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [ppsc_pkg::INDEX_W:0] ENTRIES_L = (ppsc_pkg::INDEX_W + 1)'(PALETTE_ENTRIES);

    logic                         color_format_reg;
    logic [1:0]                   scale_mode_reg;
    logic [ppsc_pkg::PHASE_W-1:0] phase_reg;
    logic [ppsc_pkg::PHASE_W-1:0] phase_cur;
    logic [ppsc_pkg::PHASE_W-1:0] phase_next;
    logic [ppsc_pkg::COLOR_W-1:0] prev_reg;
    ppsc_pkg::ppsc_stage_t        stage_reg;
    ppsc_pkg::ppsc_stage_t        stage_next;
    logic                         out_valid_reg;
    logic [ppsc_pkg::PIX_W-1:0]   out_color_reg;
    logic                         out_last_reg;

    logic                         in_xfer;
    logic                         pix_xfer;
    logic                         in_range;
    logic                         pal_we;
    logic                         stage_adv;
    logic                         out_free;
    logic                         cfg_write;
    logic [ppsc_pkg::COLOR_W-1:0] ram_rdata;
    logic [ppsc_pkg::COLOR_W-1:0] cur_color;
    logic                         emit;
    logic [ppsc_pkg::PIX_W-1:0]   packed_color;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            ppsc_pkg::REG_SCALE_MODE: prdata = {30'd0, scale_mode_reg};
            default:                  prdata = {31'd0, color_format_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_format_reg <= ppsc_pkg::FMT_RGB565;
            scale_mode_reg   <= ppsc_pkg::SCALE_DIRECT;
        end else if (cfg_write) begin
            case (paddr[2])
                ppsc_pkg::REG_SCALE_MODE: scale_mode_reg   <= pwdata[1:0];
                default:                  color_format_reg <= pwdata[0];
            endcase
        end
    end

    // handshake and input decode
    assign out_free  = !out_valid_reg || m_ready;
    assign stage_adv = stage_reg.valid && out_free;
    assign s_ready   = !stage_reg.valid || out_free;
    assign in_xfer   = s_valid && s_ready;
    assign pix_xfer  = in_xfer && (s_mode == ppsc_pkg::MODE_PIXEL);
    assign in_range  = ({1'b0, s_pixel_index} < ENTRIES_L);
    assign pal_we    = in_xfer && (s_mode == ppsc_pkg::MODE_PAL_WRITE) && in_range;

    always_comb begin
        phase_cur  = s_line_start ? ppsc_pkg::PHASE_FIRST : phase_reg;
        phase_next = phase_reg;
        if (pix_xfer) begin
            phase_next = phase_cur + 2'd1;
        end
        stage_next = stage_reg;
        if (pix_xfer) begin
            stage_next.valid    = 1'b1;
            stage_next.phase    = phase_cur;
            stage_next.in_range = in_range;
            stage_next.line_end = s_line_end;
        end else if (stage_adv) begin
            stage_next.valid = 1'b0;
        end
    end

    ppsc_ram #(
        .WIDTH(ppsc_pkg::COLOR_W),
        .DEPTH(PALETTE_ENTRIES)
    ) u_palette (
        .aclk (aclk),
        .we   (pal_we),
        .waddr(s_pixel_index[AW-1:0]),
        .wdata({s_red, s_green, s_blue}),
        .re   (pix_xfer),
        .raddr(s_pixel_index[AW-1:0]),
        .rdata(ram_rdata)
    );

    assign cur_color = stage_reg.in_range ? ram_rdata : '0;

    ppsc_color u_color (
        .prev_color  (prev_reg),
        .cur_color   (cur_color),
        .phase       (stage_reg.phase),
        .scale_mode  (scale_mode_reg),
        .color_format(color_format_reg),
        .emit        (emit),
        .packed_color(packed_color)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ppsc_pkg::PHASE_FIRST;
            prev_reg      <= '0;
            stage_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            stage_reg <= stage_next;
            if (stage_adv) begin
                prev_reg      <= cur_color;
                out_valid_reg <= emit;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (stage_adv && emit) begin
            out_color_reg <= packed_color;
            out_last_reg  <= stage_reg.line_end;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_packed_color = out_color_reg;
    assign m_line_last    = out_last_reg;

endmodule
